>>> hw/rtl/sab_pkg.sv
// Shared codes and port layout for the suffix automaton builder.
package sab_pkg;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int COUNT_W    = 12;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

endpackage

>>> hw/rtl/suffix_automaton_builder.sv
// Suffix automaton builder: top level with the construction sequencer and state stores.
//
// Each item produces exactly one result item. A clear, a refused append, an unknown
// action or a query on a failed walk goes from IDLE straight to DONE; a query reads
// its row in Q_RD first. An append passes A_LEN, then WALK for each state visited on
// the suffix-link walk, CHECK when the walk stops at an existing transition, and when
// a state is cloned REDIR for each state on the redirect walk, then FIX_Q and FIX_CUR;
// walks are amortized constant. The pace is set by the registered reads of the two
// stores: a node store (length and suffix link) and a row store that holds a whole
// transition row per word, so clearing a new row or copying a row into a clone is a
// single write. After reset the block clears the root row and root node in INIT
// before it accepts an item. A finished result sits in an output register, and the
// next item is accepted while it waits to be taken.
module suffix_automaton_builder
    import sab_pkg::*;
#(
    parameter int MAX_TEXT    = 1024,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // action[1:0], symbol[9:2], first[10]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // matched[0], status[1], state_count[13:2]
);

    localparam int NSTATES = 2 * MAX_TEXT;
    localparam int NSYM    = 1 << SYMBOL_BITS;
    localparam int IW      = $clog2(NSTATES);
    localparam int UW      = $clog2(NSTATES + 1);
    localparam int LW      = $clog2(MAX_TEXT + 1);
    localparam int NW      = LW + IW + 1;
    localparam int RW      = NSYM * IW;

    typedef enum logic [3:0] {
        INIT, IDLE, A_LEN, WALK, CHECK, REDIR, FIX_Q, FIX_CUR, Q_RD, DONE
    } state_t;

    typedef logic [NSYM-1:0][IW-1:0] row_t;

    state_t                 st_reg, st_next;
    logic [UW-1:0]          used_reg, used_next;
    logic [IW-1:0]          last_reg, last_next;
    logic [LW-1:0]          tlen_reg, tlen_next;
    logic [IW-1:0]          qpos_reg, qpos_next;
    logic                   qfail_reg, qfail_next;
    logic [IW-1:0]          cur_reg, cur_next;
    logic [IW-1:0]          p_reg, p_next;
    logic [IW-1:0]          q_reg, q_next;
    logic [IW-1:0]          cl_reg, cl_next;
    logic [SYMBOL_BITS-1:0] c_reg, c_next;
    logic [LW-1:0]          lcur_reg, lcur_next;
    logic [LW-1:0]          lp_reg, lp_next;
    logic [LW-1:0]          lq_reg, lq_next;
    logic                   matched_reg, matched_next;
    logic                   status_reg, status_next;
    logic                   mvalid_reg, mvalid_next;
    logic [OUT_DATA_W-1:0]  mdata_reg, mdata_next;

    logic          row_we, row_re;
    logic [IW-1:0] row_waddr, row_raddr;
    row_t          row_wdata, row_rd;
    logic [RW-1:0] row_rdata;

    logic          node_we, node_re;
    logic [IW-1:0] node_waddr, node_raddr;
    logic [NW-1:0] node_wdata, node_rdata;

    logic [LW-1:0] node_len;
    logic [IW-1:0] node_link;
    logic          node_null;
    logic [IW-1:0] row_hit;
    action_t       in_action;
    logic          in_first;
    logic [IW-1:0] pos_eff;
    logic          fail_eff;

    sab_ram #(.W(RW), .DEPTH(NSTATES), .AW(IW)) u_rows (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    sab_ram #(.W(NW), .DEPTH(NSTATES), .AW(IW)) u_nodes (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    assign row_rd    = row_rdata;
    assign node_len  = node_rdata[LW-1:0];
    assign node_link = node_rdata[LW+IW-1:LW];
    assign node_null = node_rdata[NW-1];
    assign row_hit   = row_rd[c_reg];

    assign in_action = action_t'(s_tdata[1:0]);
    assign in_first  = s_tdata[10];
    assign pos_eff   = in_first ? '0 : qpos_reg;
    assign fail_eff  = in_first ? 1'b0 : qfail_reg;

    assign s_tready = (st_reg == IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    always_comb
    begin
        st_next      = st_reg;
        used_next    = used_reg;
        last_next    = last_reg;
        tlen_next    = tlen_reg;
        qpos_next    = qpos_reg;
        qfail_next   = qfail_reg;
        cur_next     = cur_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        cl_next      = cl_reg;
        c_next       = c_reg;
        lcur_next    = lcur_reg;
        lp_next      = lp_reg;
        lq_next      = lq_reg;
        matched_next = matched_reg;
        status_next  = status_reg;
        mvalid_next  = mvalid_reg & ~m_tready;
        mdata_next   = mdata_reg;

        row_we     = 1'b0;
        row_waddr  = p_reg;
        row_wdata  = row_rd;
        row_re     = 1'b0;
        row_raddr  = p_reg;
        node_we    = 1'b0;
        node_waddr = cur_reg;
        node_wdata = '0;
        node_re    = 1'b0;
        node_raddr = p_reg;

        unique case (st_reg)
            INIT:
            begin
                row_we     = 1'b1;
                row_waddr  = '0;
                row_wdata  = '0;
                node_we    = 1'b1;
                node_waddr = '0;
                node_wdata = {1'b1, {IW{1'b0}}, {LW{1'b0}}};
                st_next    = IDLE;
            end
            IDLE:
            begin
                if (s_tvalid)
                begin
                    c_next       = s_tdata[2 +: SYMBOL_BITS];
                    matched_next = 1'b0;
                    status_next  = 1'b0;
                    st_next      = DONE;
                    unique case (in_action)
                        ACT_CLEAR:
                        begin
                            row_we     = 1'b1;
                            row_waddr  = '0;
                            row_wdata  = '0;
                            node_we    = 1'b1;
                            node_waddr = '0;
                            node_wdata = {1'b1, {IW{1'b0}}, {LW{1'b0}}};
                            used_next  = UW'(1);
                            last_next  = '0;
                            tlen_next  = '0;
                            qpos_next  = '0;
                            qfail_next = 1'b0;
                        end
                        ACT_APPEND:
                        begin
                            if (tlen_reg >= LW'(MAX_TEXT))
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                cur_next   = used_reg[IW-1:0];
                                used_next  = used_reg + 1'b1;
                                p_next     = last_reg;
                                node_re    = 1'b1;
                                node_raddr = last_reg;
                                st_next    = A_LEN;
                            end
                        end
                        ACT_QUERY:
                        begin
                            qpos_next  = pos_eff;
                            qfail_next = fail_eff;
                            if (!fail_eff)
                            begin
                                row_re    = 1'b1;
                                row_raddr = pos_eff;
                                st_next   = Q_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            A_LEN:
            begin
                lcur_next  = LW'(node_len + 1'b1);
                row_we     = 1'b1;
                row_waddr  = cur_reg;
                row_wdata  = '0;
                row_re     = 1'b1;
                node_re    = 1'b1;
                st_next    = WALK;
            end
            WALK:
            begin
                if (row_hit == '0)
                begin
                    row_we           = 1'b1;
                    row_wdata[c_reg] = cur_reg;
                    if (node_null)
                    begin
                        node_we    = 1'b1;
                        node_wdata = {1'b0, {IW{1'b0}}, lcur_reg};
                        last_next  = cur_reg;
                        tlen_next  = LW'(tlen_reg + 1'b1);
                        st_next    = DONE;
                    end
                    else
                    begin
                        p_next     = node_link;
                        row_re     = 1'b1;
                        row_raddr  = node_link;
                        node_re    = 1'b1;
                        node_raddr = node_link;
                    end
                end
                else
                begin
                    q_next     = row_hit;
                    lp_next    = node_len;
                    row_re     = 1'b1;
                    row_raddr  = row_hit;
                    node_re    = 1'b1;
                    node_raddr = row_hit;
                    st_next    = CHECK;
                end
            end
            CHECK:
            begin
                if (LW'(lp_reg + 1'b1) == node_len)
                begin
                    node_we    = 1'b1;
                    node_wdata = {1'b0, q_reg, lcur_reg};
                    last_next  = cur_reg;
                    tlen_next  = LW'(tlen_reg + 1'b1);
                    st_next    = DONE;
                end
                else
                begin
                    // split: clone q with its whole row and link
                    cl_next    = used_reg[IW-1:0];
                    used_next  = used_reg + 1'b1;
                    lq_next    = node_len;
                    row_we     = 1'b1;
                    row_waddr  = used_reg[IW-1:0];
                    node_we    = 1'b1;
                    node_waddr = used_reg[IW-1:0];
                    node_wdata = {node_null, node_link, LW'(lp_reg + 1'b1)};
                    row_re     = 1'b1;
                    node_re    = 1'b1;
                    st_next    = REDIR;
                end
            end
            REDIR:
            begin
                if (row_hit == q_reg)
                begin
                    row_we           = 1'b1;
                    row_wdata[c_reg] = cl_reg;
                    if (node_null)
                    begin
                        st_next = FIX_Q;
                    end
                    else
                    begin
                        p_next     = node_link;
                        row_re     = 1'b1;
                        row_raddr  = node_link;
                        node_re    = 1'b1;
                        node_raddr = node_link;
                    end
                end
                else
                begin
                    st_next = FIX_Q;
                end
            end
            FIX_Q:
            begin
                node_we    = 1'b1;
                node_waddr = q_reg;
                node_wdata = {1'b0, cl_reg, lq_reg};
                st_next    = FIX_CUR;
            end
            FIX_CUR:
            begin
                node_we    = 1'b1;
                node_wdata = {1'b0, cl_reg, lcur_reg};
                last_next  = cur_reg;
                tlen_next  = LW'(tlen_reg + 1'b1);
                st_next    = DONE;
            end
            Q_RD:
            begin
                if (row_hit != '0)
                begin
                    qpos_next    = row_hit;
                    matched_next = 1'b1;
                end
                else
                begin
                    qfail_next = 1'b1;
                end
                st_next = DONE;
            end
            DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {{(OUT_DATA_W - COUNT_W - 2){1'b0}},
                                   COUNT_W'(used_reg), status_reg, matched_reg};
                    st_next     = IDLE;
                end
            end
            default:
            begin
                st_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= INIT;
            used_reg    <= UW'(1);
            last_reg    <= '0;
            tlen_reg    <= '0;
            qpos_reg    <= '0;
            qfail_reg   <= 1'b0;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            used_reg    <= used_next;
            last_reg    <= last_next;
            tlen_reg    <= tlen_next;
            qpos_reg    <= qpos_next;
            qfail_reg   <= qfail_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        cl_reg      <= cl_next;
        c_reg       <= c_next;
        lcur_reg    <= lcur_next;
        lp_reg      <= lp_next;
        lq_reg      <= lq_next;
        matched_reg <= matched_next;
        status_reg  <= status_next;
        mdata_reg   <= mdata_next;
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(NSTATES))
        else $error("state count beyond capacity");

    a_text_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tlen_reg <= LW'(MAX_TEXT))
        else $error("text length beyond capacity");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mvalid_reg) |-> $past(st_reg == DONE))
        else $error("result raised outside completion");

    a_states_track_text: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == IDLE) |-> (used_reg <= UW'({1'b0, tlen_reg} * 2 + 1)))
        else $error("more states than text allows");

endmodule

>>> hw/rtl/sab_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read port.
module sab_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> verif/sab_checker.sv
// Checker for the suffix automaton builder: mirrors the automaton and compares each result.
module sab_checker
    import sab_pkg::*;
#(
    parameter int MAX_TEXT    = 1024,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    pending,
    output int                    results_seen
);

    localparam int NST  = 2 * MAX_TEXT;
    localparam int NSYM = 1 << SYMBOL_BITS;

    // laid out as in the result tdata, lowest field last
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               status;
        logic               matched;
    } answer_t;

    int   node_len  [NST];
    int   node_link [NST];
    int   goto_tab  [NST][NSYM];
    int   n_used;
    int   tail;
    int   text_len;
    int   walk_pos;
    bit   walk_dead;
    answer_t answers_due[$];

    task automatic clear_automaton();
        foreach (goto_tab[i, j]) goto_tab[i][j] = 0;
        node_len[0] = 0;
        node_link[0] = -1;
        n_used = 1;
        tail = 0;
        text_len = 0;
        walk_pos = 0;
        walk_dead = 0;
    endtask

    task automatic extend_text(input int c);
        int cur, p, q, cl;
        cur = n_used++;
        p = tail;
        node_len[cur] = node_len[tail] + 1;
        for (int j = 0; j < NSYM; j++) goto_tab[cur][j] = 0;
        while (p != -1 && goto_tab[p][c] == 0) begin
            goto_tab[p][c] = cur;
            p = node_link[p];
        end
        if (p == -1) begin
            node_link[cur] = 0;
        end
        else begin
            q = goto_tab[p][c];
            if (node_len[p] + 1 == node_len[q]) begin
                node_link[cur] = q;
            end
            else begin
                cl = n_used++;
                node_len[cl] = node_len[p] + 1;
                for (int j = 0; j < NSYM; j++) goto_tab[cl][j] = goto_tab[q][j];
                node_link[cl] = node_link[q];
                while (p != -1 && goto_tab[p][c] == q) begin
                    goto_tab[p][c] = cl;
                    p = node_link[p];
                end
                node_link[q] = cl;
                node_link[cur] = cl;
            end
        end
        tail = cur;
        text_len++;
    endtask

    task automatic predict_answer(input logic [IN_DATA_W-1:0] d);
        action_t act;
        int      c;
        answer_t a;
        act = action_t'(d[1:0]);
        c = int'(d[9:2]) & (NSYM - 1);
        a = '0;
        case (act)
            ACT_CLEAR: clear_automaton();
            ACT_APPEND:
                if (text_len >= MAX_TEXT) a.status = 1'b1;
                else extend_text(c);
            ACT_QUERY: begin
                if (d[10]) begin
                    walk_pos = 0;
                    walk_dead = 0;
                end
                if (!walk_dead) begin
                    if (goto_tab[walk_pos][c] != 0) begin
                        walk_pos = goto_tab[walk_pos][c];
                        a.matched = 1'b1;
                    end
                    else begin
                        walk_dead = 1;
                    end
                end
            end
            default: ;
        endcase
        a.count = n_used[COUNT_W-1:0];
        answers_due.push_back(a);
    endtask

    initial begin
        fail_count = 0;
        results_seen = 0;
        clear_automaton();
    end

    assign pending = answers_due.size();

    always @(posedge clk) begin
        answer_t exp_a, got;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got = answer_t'(m_tdata[13:0]);
                results_seen++;
                if (answers_due.size() == 0) begin
                    $error("result with none expected: %h", m_tdata);
                    fail_count++;
                end
                else begin
                    exp_a = answers_due.pop_front();
                    if (got.matched !== exp_a.matched) begin
                        $error("matched: expected %0d got %0d", exp_a.matched, got.matched);
                        fail_count++;
                    end
                    if (got.status !== exp_a.status) begin
                        $error("status: expected %0d got %0d", exp_a.status, got.status);
                        fail_count++;
                    end
                    if (got.count !== exp_a.count) begin
                        $error("state_count: expected %0d got %0d", exp_a.count, got.count);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_answer(s_tdata);
        end
    end

endmodule

>>> verif/tb_suffix_automaton_builder.sv
// Testbench top for the suffix automaton builder: stimulus, idling, verdict.
module tb_suffix_automaton_builder;
    import sab_pkg::*;

    localparam int MAX_TEXT = 1024;
    localparam int WATCHDOG = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    fail_count;
    int                    pending;
    int                    results_seen;
    int                    items_sent;
    int                    idle_cycles;
    int                    out_cycle;
    bit                    calm;
    bit                    hold_off;
    bit                    stim_done;

    suffix_automaton_builder #(.MAX_TEXT(MAX_TEXT), .SYMBOL_BITS(8)) dut (.*);

    sab_checker #(.MAX_TEXT(MAX_TEXT), .SYMBOL_BITS(8)) u_check (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Receiver: random stalls, one long hold-off, and a calm stretch.
    always @(posedge clk) begin
        out_cycle <= out_cycle + 1;
        if (out_cycle >= 3000 && out_cycle < 3400) m_tready <= 1'b0;
        else if (calm) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(99) >= 28);
    end

    // Items that accept only while this process holds tvalid high.
    task automatic send_item(input action_t act, input int sym, input bit first);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[1:0] = act;
        d[9:2] = sym[7:0];
        d[10] = first;
        while (!calm && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_run(input int n, input int alpha);
        int pat_len;
        pat_len = 0;
        repeat (n) begin
            case ($urandom_range(9))
                0, 1, 2, 3: send_item(ACT_APPEND, $urandom_range(alpha - 1), 0);
                4, 5, 6, 7: begin
                    send_item(ACT_QUERY, $urandom_range(alpha - 1), pat_len == 0);
                    pat_len = ($urandom_range(5) == 0) ? 0 : pat_len + 1;
                end
                8: send_item(action_t'($urandom_range(3)), $urandom_range(255),
                             $urandom_range(1));
                default: send_item(ACT_QUERY, $urandom_range(255), $urandom_range(1));
            endcase
        end
    endtask

    initial begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        out_cycle = 0;
        items_sent = 0;
        calm = 1'b0;
        stim_done = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: "ababb" style text, splits, queries, wide symbols, unknown action.
        send_item(ACT_QUERY, 0, 1);
        send_item(ACT_APPEND, 8'h00, 0);
        send_item(ACT_APPEND, 8'hFF, 0);
        send_item(ACT_APPEND, 8'h00, 0);
        send_item(ACT_APPEND, 8'hFF, 0);
        send_item(ACT_APPEND, 8'hFF, 0);
        send_item(ACT_QUERY, 8'hFF, 1);
        send_item(ACT_QUERY, 8'hFF, 0);
        send_item(ACT_QUERY, 8'h00, 0);
        send_item(ACT_APPEND, 8'h00, 0);
        send_item(ACT_QUERY, 8'h00, 0);
        send_item(ACT_QUERY, 8'h55, 0);
        send_item(ACT_QUERY, 8'h00, 0);
        send_item(ACT_QUERY, 8'hAA, 1);
        send_item(ACT_NONE, 8'hFF, 1);
        send_item(ACT_CLEAR, 8'hFF, 1);
        send_item(ACT_QUERY, 8'h00, 1);

        send_run(150, 2);
        calm = 1'b1;
        send_run(100, 4);
        calm = 1'b0;
        send_item(ACT_CLEAR, 0, 0);
        // Fill to capacity, then refused appends and queries on the full text.
        // The long hold-off falls in here.
        repeat (MAX_TEXT + 4) send_item(ACT_APPEND, $urandom_range(2), 0);
        send_run(60, 3);
        send_item(ACT_CLEAR, 0, 0);
        send_run(40, 256);
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        idle_cycles = 0;
        wait (items_sent > 0);
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (stim_done && pending == 0) begin
                repeat (40) @(posedge clk);
                $display("Ran %0d items with %0d results: clears, appends to capacity,",
                         items_sent, results_seen);
                $display("clone splits, query walks and restarts, wide and unknown items.");
                if (fail_count == 0 && pending == 0)
                    $display("suffix_automaton_builder test passed");
                else
                    $display("suffix_automaton_builder test failed");
                $finish;
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("suffix_automaton_builder test failed");
                $finish;
            end
        end
    end

endmodule
